// ===== rtl/mm3_pkg.sv =====
package mm3_pkg;

    localparam int DIM = 3;
    localparam int CELLS = DIM * DIM;
    localparam int CNT_W = 5;
    localparam int ADDR_W = 4;
    localparam int IDX_W = 2;

    localparam logic [CNT_W-1:0] LAST_LOAD = CNT_W'(2 * CELLS - 1);
    localparam logic [CNT_W-1:0] B_BASE = CNT_W'(CELLS);
    localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(DIM - 1);

    typedef enum logic {
        ST_LOAD,
        ST_CALC
    } t_state;

    typedef struct packed {
        logic             valid;
        logic             k_first;
        logic             k_last;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             last;
    } t_tag;

endpackage

// ===== rtl/matrix_multiply_3x3_unit.sv =====
// The first result follows the transfer of the eighteenth element through the read registers,
// the product register, the accumulator and the output register. One shared multiplier computes
// 27 products, one per cycle while the output is not stalled; no new element is taken until all are issued.
// Input stall stays high in the compute state; output stall holds the whole datapath.
// Reset clears the load count, the sequencer and all valid flags; the matrix stores are not
// cleared, and their contents reach a valid result only after a full group has been written.
module matrix_multiply_3x3_unit #(
    parameter int ELEM_WIDTH = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [ELEM_WIDTH-1:0] i_elem_value,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [ELEM_WIDTH-1:0] o_product_value,
    output logic [1:0]                   o_row_index,
    output logic [1:0]                   o_col_index,
    output logic                         o_last_flag
);
    import mm3_pkg::*;

    localparam int PROD_W = 2 * ELEM_WIDTH;
    localparam int SUM_W = PROD_W + 2;

    logic [ELEM_WIDTH-1:0] a_mem [CELLS];
    logic [ELEM_WIDTH-1:0] b_mem [CELLS];

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [IDX_W-1:0] r_row, n_row;
    logic [IDX_W-1:0] r_col, n_col;
    logic [IDX_W-1:0] r_k, n_k;

    t_tag tag0;
    t_tag r_tag1, r_tag2, r_tag3;

    logic signed [ELEM_WIDTH-1:0] r_a_rd, r_b_rd;
    logic signed [PROD_W-1:0]     r_prod;
    logic signed [SUM_W-1:0]      r_acc;
    logic signed [SUM_W-1:0]      shifted;
    logic [SUM_W-ELEM_WIDTH:0]    top_bits;
    logic                         overflow;
    logic [ELEM_WIDTH-1:0]        sat_value;

    logic                  accept;
    logic                  en;
    logic [ADDR_W-1:0]     a_addr, b_addr;
    logic [CNT_W-1:0]      b_wr_cnt;

    logic                  r_out_valid;
    logic [ELEM_WIDTH-1:0] r_out_value;
    logic [IDX_W-1:0]      r_out_row, r_out_col;
    logic                  r_out_last;

    assign o_stall = (r_state != ST_LOAD);
    assign accept = i_valid && !o_stall;
    assign en = !r_out_valid || !i_stall;

    assign a_addr = ADDR_W'({r_row, 1'b0}) + ADDR_W'(r_row) + ADDR_W'(r_k);
    assign b_addr = ADDR_W'({r_k, 1'b0}) + ADDR_W'(r_k) + ADDR_W'(r_col);
    assign b_wr_cnt = r_count - B_BASE;

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_row = r_row;
        n_col = r_col;
        n_k = r_k;
        tag0.valid = (r_state == ST_CALC);
        tag0.k_first = (r_k == '0);
        tag0.k_last = (r_k == IDX_MAX);
        tag0.row = r_row;
        tag0.col = r_col;
        tag0.last = (r_row == IDX_MAX) && (r_col == IDX_MAX);
        case (r_state)
            ST_LOAD: begin
                if (accept) begin
                    if (r_count == LAST_LOAD) begin
                        n_count = '0;
                        n_state = ST_CALC;
                        n_row = '0;
                        n_col = '0;
                        n_k = '0;
                    end else begin
                        n_count = r_count + 1'b1;
                    end
                end
            end
            ST_CALC: begin
                if (en) begin
                    if (r_k == IDX_MAX) begin
                        n_k = '0;
                        if (r_col == IDX_MAX) begin
                            n_col = '0;
                            if (r_row == IDX_MAX) begin
                                n_row = '0;
                                n_state = ST_LOAD;
                            end else begin
                                n_row = r_row + 1'b1;
                            end
                        end else begin
                            n_col = r_col + 1'b1;
                        end
                    end else begin
                        n_k = r_k + 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_count <= '0;
            r_row <= '0;
            r_col <= '0;
            r_k <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_row <= n_row;
            r_col <= n_col;
            r_k <= n_k;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (r_count < B_BASE) begin
                a_mem[r_count[ADDR_W-1:0]] <= i_elem_value;
            end else begin
                b_mem[b_wr_cnt[ADDR_W-1:0]] <= i_elem_value;
            end
        end
        if (en) begin
            r_a_rd <= a_mem[a_addr];
            r_b_rd <= b_mem[b_addr];
        end
    end

    assign shifted = r_acc >>> FRAC_BITS;
    assign top_bits = shifted[SUM_W-1:ELEM_WIDTH-1];
    assign overflow = !((&top_bits) || (~|top_bits));

    always_comb begin
        if (overflow) begin
            sat_value = shifted[SUM_W-1] ? {1'b1, {(ELEM_WIDTH-1){1'b0}}}
                                         : {1'b0, {(ELEM_WIDTH-1){1'b1}}};
        end else begin
            sat_value = shifted[ELEM_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prod <= r_a_rd * r_b_rd;
            if (r_tag2.k_first) begin
                r_acc <= SUM_W'(r_prod);
            end else begin
                r_acc <= r_acc + SUM_W'(r_prod);
            end
            if (r_tag3.valid && r_tag3.k_last) begin
                r_out_value <= sat_value;
                r_out_row <= r_tag3.row;
                r_out_col <= r_tag3.col;
                r_out_last <= r_tag3.last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1 <= '0;
            r_tag2 <= '0;
            r_tag3 <= '0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_tag1 <= tag0;
            r_tag2 <= r_tag1;
            r_tag3 <= r_tag2;
            r_out_valid <= r_tag3.valid && r_tag3.k_last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_product_value = r_out_value;
    assign o_row_index = r_out_row;
    assign o_col_index = r_out_col;
    assign o_last_flag = r_out_last;

endmodule
